// ===== rtl/core/pxu_pkg.sv =====
// ----------------------------------------------------------------------------
// pxu_pkg
// Shared constants, types and codes of the pixel replicate upscaler.
// ----------------------------------------------------------------------------
package pxu_pkg;

    // Largest source row and largest enlargement factor the block supports.
    localparam int MAX_WIDTH = 4096;
    localparam int MAX_SCALE = 16;

    // Fixed field and register widths.
    localparam int PIX_W       = 24;
    localparam int PAD_W       = 2;
    localparam int SCALE_REG_W = 5;
    localparam int WIDTH_REG_W = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;

    // Derived widths.
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int SCNT_W = $clog2(MAX_SCALE + 1);
    localparam int REP_W  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

    // Command queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 1'b1;

    // Request types.
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    // One classified request: a pixel to be sent out cnt times.
    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [SCNT_W-1:0] cnt;
        logic              at_end;
        logic [PAD_W-1:0]  pad;
        logic              misuse;
    } t_cmd;

endpackage

// ===== rtl/core/pxu_front.sv =====
// ----------------------------------------------------------------------------
// pxu_front
// Accepts requests, checks them against the phase, keeps the column and
// replay state, owns the line store and hands one command per request to
// the command queue.
// ----------------------------------------------------------------------------
module pxu_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pxu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pxu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_req_type,
    input  logic [pxu_pkg::PIX_W-1:0]       i_pixel,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output pxu_pkg::t_cmd                   o_q_cmd
);
    import pxu_pkg::*;

    // Configuration registers.
    logic [SCALE_REG_W-1:0] r_scale;
    logic [WIDTH_REG_W-1:0] r_width;

    // Row and phase state.
    logic [COL_W-1:0] r_col;
    logic [REP_W-1:0] r_replays;
    logic             r_replaying;

    // Line store and its registered read port.
    logic [PIX_W-1:0] r_line [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_data;

    // Classification stage.
    logic              r_s1_valid;
    logic              r_s1_pull;
    logic              r_s1_misuse;
    logic [PIX_W-1:0]  r_s1_pixel;
    logic [SCNT_W-1:0] r_s1_cnt;
    logic              r_s1_at_end;
    logic [PAD_W-1:0]  r_s1_pad;

    logic              w_accept;
    logic              w_s1_move;
    logic              w_misuse;
    logic              w_at_end;
    logic [SCNT_W-1:0] w_scale;
    logic [WCNT_W-1:0] w_width;
    logic [PAD_W-1:0]  w_pad;

    logic [COL_W-1:0]  n_col;
    logic [REP_W-1:0]  n_replays;
    logic              n_replaying;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_REG_W'(1);
            r_width <= WIDTH_REG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCALE: r_scale <= i_cfg_data[SCALE_REG_W-1:0];
                CFG_WIDTH: r_width <= i_cfg_data[WIDTH_REG_W-1:0];
                default:   ;
            endcase
        end
    end

    // Effective scale and width: zero counts as one, large values saturate.
    always_comb begin
        if (r_scale == '0) begin
            w_scale = SCNT_W'(1);
        end else if (32'(r_scale) > MAX_SCALE) begin
            w_scale = SCNT_W'(MAX_SCALE);
        end else begin
            w_scale = SCNT_W'(r_scale);
        end
        if (r_width == '0) begin
            w_width = WCNT_W'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_width = WCNT_W'(MAX_WIDTH);
        end else begin
            w_width = WCNT_W'(r_width);
        end
    end

    // Pad bytes: three bytes per pixel, so the pad is width*scale modulo four.
    always_comb begin
        logic [3:0] prod;
        prod  = 2'(w_width) * 2'(w_scale);
        w_pad = prod[PAD_W-1:0];
    end

    // Handshake with the upstream side and with the queue.
    assign o_stall   = r_s1_valid && i_q_full;
    assign w_accept  = i_valid && !o_stall;
    assign w_s1_move = r_s1_valid && !i_q_full;
    assign w_misuse  = (i_req_type == REQ_PULL) != r_replaying;
    assign w_at_end  = (WCNT_W'(r_col) + WCNT_W'(1)) >= w_width;

    // Next column and replay state for an accepted request of the right type.
    always_comb begin
        n_col       = r_col;
        n_replays   = r_replays;
        n_replaying = r_replaying;
        if (w_accept && !w_misuse) begin
            if (!w_at_end) begin
                n_col = r_col + COL_W'(1);
            end else begin
                n_col = '0;
                if (!r_replaying) begin
                    if (w_scale > SCNT_W'(1)) begin
                        n_replays   = REP_W'(w_scale - SCNT_W'(1));
                        n_replaying = 1'b1;
                    end
                end else if (r_replays <= REP_W'(1)) begin
                    n_replays   = '0;
                    n_replaying = 1'b0;
                end else begin
                    n_replays = r_replays - REP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_replays   <= '0;
            r_replaying <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_replays   <= n_replays;
            r_replaying <= n_replaying;
        end
    end

    // Line store: pushes write the current column, the read is registered.
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_misuse && !r_replaying) begin
            r_line[r_col] <= i_pixel;
        end
        if (w_accept) begin
            r_rd_data <= r_line[r_col];
        end
    end

    // Classification stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Classification stage payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pull   <= r_replaying;
            r_s1_misuse <= w_misuse;
            r_s1_pixel  <= i_pixel;
            r_s1_cnt    <= w_misuse ? SCNT_W'(1) : w_scale;
            r_s1_at_end <= !w_misuse && w_at_end;
            r_s1_pad    <= w_misuse ? '0 : w_pad;
        end
    end

    // Command to the queue; replays take the pixel from the line store.
    assign o_q_push = w_s1_move;
    always_comb begin
        o_q_cmd.cnt    = r_s1_cnt;
        o_q_cmd.at_end = r_s1_at_end;
        o_q_cmd.pad    = r_s1_pad;
        o_q_cmd.misuse = r_s1_misuse;
        if (r_s1_misuse) begin
            o_q_cmd.pixel = '0;
        end else if (r_s1_pull) begin
            o_q_cmd.pixel = r_rd_data;
        end else begin
            o_q_cmd.pixel = r_s1_pixel;
        end
    end

endmodule

// ===== rtl/core/pxu_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// pxu_cmd_fifo
// Short command queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module pxu_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pxu_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output pxu_pkg::t_cmd o_head
);
    import pxu_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = r_count == QCNT_W'(QDEPTH);
    assign o_empty   = r_count == '0;
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_head    = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == QDEPTH - 1) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == QDEPTH - 1) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/pxu_back.sv =====
// ----------------------------------------------------------------------------
// pxu_back
// Takes commands from the queue and sends each pixel out the requested
// number of times, one copy per cycle while the output is not stalled,
// through an output register.
module pxu_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  pxu_pkg::t_cmd               i_q_head,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [pxu_pkg::PIX_W-1:0]   o_out_pixel,
    output logic [pxu_pkg::PAD_W-1:0]   o_pad_bytes,
    output logic                        o_row_end,
    output logic                        o_last,
    output logic                        o_misuse
);
    import pxu_pkg::*;

    logic              r_act;
    t_cmd              r_cmd;
    logic [SCNT_W-1:0] r_rem;
    logic              r_out_valid;
    logic              w_adv;
    logic              w_fin;

    // A copy moves into the output register whenever that register frees up.
    assign w_adv   = r_act && (!r_out_valid || !i_stall);
    assign w_fin   = r_rem == SCNT_W'(1);
    assign o_q_pop = !i_q_empty && (!r_act || (w_adv && w_fin));
    assign o_valid = r_out_valid;

    // Control: active command and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_act <= 1'b1;
            end else if (w_adv && w_fin) begin
                r_act <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: current command, copies left and the output register.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_out_pixel <= r_cmd.pixel;
            o_pad_bytes <= (w_fin && r_cmd.at_end) ? r_cmd.pad : '0;
            o_row_end   <= w_fin && r_cmd.at_end;
            o_last      <= w_fin;
            o_misuse    <= r_cmd.misuse;
        end
        if (o_q_pop) begin
            r_cmd <= i_q_head;
            r_rem <= i_q_head.cnt;
        end else if (w_adv) begin
            r_rem <= r_rem - SCNT_W'(1);
        end
    end

endmodule

// ===== rtl/core/pixel_replicate_upscaler.sv =====
// ----------------------------------------------------------------------------
// pixel_replicate_upscaler
// Integer nearest-neighbor upscaler for 24-bit pixels with a row store.
// ----------------------------------------------------------------------------
// The block sends one result pixel per cycle while the output is not stalled.
// A request produces as many results as the effective scale (zero counts as
// one, values above sixteen count as sixteen), and one for a request of the
// wrong type; the copy counter of the back part counts them out, one copy per
// cycle while the output is not stalled. The front part takes a new request
// every cycle while the four-entry command queue has room, so requests pile
// up ahead of a busy or stalled output. When the block is empty, a request
// passes the classification stage, the command queue and the active-command
// register before its first result enters the output register. The 4096 x 24
// line store is not cleared: a replay of a column that was never pushed returns
// undefined data. Write the configuration only while no request is in flight.
module pixel_replicate_upscaler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pxu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pxu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_req_type,
    input  logic [pxu_pkg::PIX_W-1:0]       i_pixel,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [pxu_pkg::PIX_W-1:0]       o_out_pixel,
    output logic [pxu_pkg::PAD_W-1:0]       o_pad_bytes,
    output logic                            o_row_end,
    output logic                            o_last,
    output logic                            o_misuse
);
    import pxu_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_cmd q_in_cmd;
    t_cmd q_head;

    // Front part: request checking, row state and line store.
    pxu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_pixel    (i_pixel),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in_cmd)
    );

    // Command queue between the two parts.
    pxu_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Back part: pixel replication and output register.
    pxu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_pixel (o_out_pixel),
        .o_pad_bytes (o_pad_bytes),
        .o_row_end   (o_row_end),
        .o_last      (o_last),
        .o_misuse    (o_misuse)
    );

endmodule

// ===== rtl/core/pxu_checker.sv =====
// ----------------------------------------------------------------------------
// pxu_checker
// Port-level checks of the upscaler, bound to the top level.
// ----------------------------------------------------------------------------
module pxu_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [pxu_pkg::PIX_W-1:0]   o_out_pixel,
    input logic [pxu_pkg::PAD_W-1:0]   o_pad_bytes,
    input logic                        o_row_end,
    input logic                        o_last
    ,
    input logic                        o_misuse
);
    import pxu_pkg::*;

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // The end of an output row is always the final copy of its request.
    a_row_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_row_end |-> o_last)
        else $error("row end on a copy that is not the last");

    // Pad bytes appear only at the end of a row.
    a_pad_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_pad_bytes != '0) |-> o_row_end)
        else $error("pad bytes away from row end");

    // A misuse answer is a single, empty result.
    a_misuse_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_misuse |-> o_last && !o_row_end && (o_pad_bytes == '0)
            && (o_out_pixel == '0))
        else $error("malformed misuse result");

endmodule

bind pixel_replicate_upscaler pxu_checker u_pxu_checker (.*);

// ===== bench/tb_pixel_replicate_upscaler.sv =====
// ----------------------------------------------------------------------------
// tb_pixel_replicate_upscaler
// Self-checking bench for the nearest-neighbor pixel replicate upscaler.
// Requests are pushed and pulled through the valid/stall port. A predictor
// mirrors the row store, column, replay count and phase, and builds the
// pixel copies that every accepted request must produce. Each result is
// compared against the oldest predicted copy.
// ----------------------------------------------------------------------------
module tb_pixel_replicate_upscaler;
    timeunit 1ns;
    timeprecision 1ps;

    import pxu_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;

    // One output pixel as the block reports it.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [PAD_W-1:0] pad;
        logic             row_end;
        logic             last;
        logic             misuse;
    } t_pixel_result;

    // Predicts the copies each request produces and checks them as they arrive.
    class upscale_predictor;
        logic [PIX_W-1:0]       row_mem [MAX_WIDTH];
        logic [COL_W-1:0]       col;
        logic [REP_W-1:0]       rows_owed;
        bit                     replaying;
        logic [SCALE_REG_W-1:0] scale_reg;
        logic [WIDTH_REG_W-1:0] width_reg;
        int                     written_len;
        t_pixel_result          expected_pixels[$];
        int                     errors;

        function new();
            col         = '0;
            rows_owed   = '0;
            replaying   = 1'b0;
            scale_reg   = SCALE_REG_W'(1);
            width_reg   = WIDTH_REG_W'(1);
            written_len = 0;
            errors      = 0;
        endfunction

        function int eff_scale();
            if (scale_reg == 0) return 1;
            if (int'(scale_reg) > MAX_SCALE) return MAX_SCALE;
            return int'(scale_reg);
        endfunction

        function int eff_width();
            if (width_reg == 0) return 1;
            if (int'(width_reg) > MAX_WIDTH) return MAX_WIDTH;
            return int'(width_reg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_SCALE) scale_reg = data[SCALE_REG_W-1:0];
            else width_reg = data[WIDTH_REG_W-1:0];
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // Work out the copies for one accepted request and advance the state.
        function void note_request(logic req, logic [PIX_W-1:0] pix);
            int               s;
            int               w;
            int               c;
            bit               at_end;
            logic [PAD_W-1:0] pad;
            logic [PIX_W-1:0] src;
            t_pixel_result    r;
            s   = eff_scale();
            w   = eff_width();
            pad = PAD_W'((4 - ((w * s * 3) % 4)) % 4);

            // A request of the wrong type gives one flagged result only.
            if ((req == REQ_PULL) != replaying) begin
                r = '{pixel: '0, pad: '0, row_end: 1'b0, last: 1'b1, misuse: 1'b1};
                expected_pixels.push_back(r);
                return;
            end

            c      = int'(col);
            at_end = (c + 1 >= w);
            if (!replaying) begin
                row_mem[c] = pix;
                if (c + 1 > written_len) written_len = c + 1;
                src = pix;
            end else begin
                src = row_mem[c];
            end

            for (int k = 0; k < s; k++) begin
                r.pixel   = src;
                r.last    = (k == s - 1);
                r.row_end = r.last && at_end;
                r.pad     = r.row_end ? pad : '0;
                r.misuse  = 1'b0;
                expected_pixels.push_back(r);
            end

            // Column and phase bookkeeping.
            if (!at_end) begin
                col = COL_W'(c + 1);
            end else begin
                col = '0;
                if (!replaying) begin
                    if (s > 1) begin
                        rows_owed = REP_W'(s - 1);
                        replaying = (rows_owed != 0);
                    end
                end else if (rows_owed <= 1) begin
                    rows_owed = '0;
                    replaying = 1'b0;
                end else begin
                    rows_owed = rows_owed - 1'b1;
                end
            end
        endfunction

        // Compare one accepted result with the oldest predicted copy.
        function void check_pixel(t_pixel_result got);
            t_pixel_result exp_r;
            if (expected_pixels.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: pixel %06h pad %0d row_end %0d last %0d misuse %0d",
                             got.pixel, got.pad, got.row_end, got.last, got.misuse);
                return;
            end
            exp_r = expected_pixels.pop_front();
            if (got !== exp_r) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected pixel %06h pad %0d row_end %0d last %0d misuse %0d",
                             exp_r.pixel, exp_r.pad, exp_r.row_end, exp_r.last, exp_r.misuse);
                    $display("          actual   pixel %06h pad %0d row_end %0d last %0d misuse %0d",
                             got.pixel, got.pad, got.row_end, got.last, got.misuse);
                end
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_valid;
    logic                   o_stall;
    logic                   i_req_type;
    logic [PIX_W-1:0]       i_pixel;
    logic                   o_valid;
    logic                   i_stall;
    logic [PIX_W-1:0]       o_out_pixel;
    logic [PAD_W-1:0]       o_pad_bytes;
    logic                   o_row_end;
    logic                   o_last;
    logic                   o_misuse;

    upscale_predictor sb;
    int               send_idle_pct = 0;
    int               stall_pct     = 0;
    int unsigned      cycle_count   = 0;
    int               sender_idle [4] = '{0, 62, 0, 25};
    int               receiver_idle [4] = '{0, 0, 62, 25};

    pixel_replicate_upscaler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req_type  (i_req_type),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_pixel (o_out_pixel),
        .o_pad_bytes (o_pad_bytes),
        .o_row_end   (o_row_end),
        .o_last      (o_last),
        .o_misuse    (o_misuse)
    );

    // Clock with a 12 ns period.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Receiver stalls at random with the current phase's rate.
    always @(posedge i_clk) i_stall <= ($urandom_range(99) < stall_pct);

    // Every accepted result goes to the checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_pixel('{pixel: o_out_pixel, pad: o_pad_bytes, row_end: o_row_end,
                             last: o_last, misuse: o_misuse});
    end

    // Hard stop if the block hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // Present one request, with an optional random gap first, until accepted.
    task automatic send_request(input logic req, input logic [PIX_W-1:0] pix);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_pixel    <= pix;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(req, pix);
    endtask

    // Stop sending and let every predicted copy come out.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both registers; the unused upper bits of the scale word are random.
    task automatic configure(input int scale_val, input int width_val);
        logic [CFG_DATA_W-1:0] scale_word;
        logic [CFG_DATA_W-1:0] width_word;
        scale_word = CFG_DATA_W'($urandom);
        scale_word[SCALE_REG_W-1:0] = SCALE_REG_W'(scale_val);
        width_word = CFG_DATA_W'(width_val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SCALE;
        i_cfg_data <= scale_word;
        @(posedge i_clk);
        sb.write_reg(CFG_SCALE, scale_word);
        i_cfg_idx  <= CFG_WIDTH;
        i_cfg_data <= width_word;
        @(posedge i_clk);
        sb.write_reg(CFG_WIDTH, width_word);
        i_cfg_we <= 1'b0;
    endtask

    // Random setting, mostly small; a replay never widens past the stored row.
    task automatic random_configure();
        int s;
        int w;
        int w_eff;
        case ($urandom_range(9))
            0: s = 0;
            1: s = $urandom_range(31, 17);
            2: s = MAX_SCALE;
            default: s = $urandom_range(5, 1);
        endcase
        case ($urandom_range(19))
            0: w = 0;
            1: w = $urandom_range(8191, MAX_WIDTH + 1);
            2: w = $urandom_range(MAX_WIDTH, 100);
            default: w = $urandom_range(6, 1);
        endcase
        w_eff = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
        if (sb.replaying && w_eff > sb.written_len) w = $urandom_range(sb.written_len, 1);
        configure(s, w);
    endtask

    // Send well-formed requests until the block is back at the start of a row.
    task automatic finish_row();
        while (sb.replaying || sb.col != 0)
            send_request(sb.replaying ? REQ_PULL : REQ_PUSH, PIX_W'($urandom));
    endtask

    initial begin
        logic req;
        sb = new();
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_SCALE;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_req_type <= REQ_PUSH;
        i_pixel    <= '0;
        i_stall    <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: field extremes and a pull in the push phase.
        send_request(REQ_PUSH, '0);
        send_request(REQ_PUSH, '1);
        send_request(REQ_PULL, 24'h5A5A5A);

        // Zero registers behave as one.
        wait_idle();
        configure(0, 0);
        send_request(REQ_PUSH, 24'hA5A5A5);

        // Two-pixel row at scale three, with a push during the replay.
        wait_idle();
        configure(3, 2);
        send_request(REQ_PUSH, 24'h123456);
        send_request(REQ_PUSH, 24'hFEDCBA);
        send_request(REQ_PUSH, 24'h0F0F0F);
        repeat (4) send_request(REQ_PULL, PIX_W'($urandom));

        // Saturated scale: one pixel then fifteen replayed rows.
        wait_idle();
        configure(31, 1);
        send_request(REQ_PUSH, 24'hC3C3C3);
        finish_row();

        // Random requests through each idling pattern.
        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            send_idle_pct = sender_idle[ph];
            stall_pct     = receiver_idle[ph];
            random_configure();
            for (int n = 0; n < 26; n++) begin
                if ($urandom_range(14) == 0) begin
                    wait_idle();
                    random_configure();
                end
                req = sb.replaying ? REQ_PULL : REQ_PUSH;
                if ($urandom_range(9) == 0) req = ~req;
                send_request(req, PIX_W'($urandom));
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
